FILE: design/pidaw_pkg.sv
// ----------------------------------------------------------------------------
// PID controller package
// Widths, register map, microcode word layout and the control program.
// ----------------------------------------------------------------------------
package pidaw_pkg;

  localparam int unsigned DataW    = 16;
  localparam int unsigned ErrW     = 17;
  localparam int unsigned DiffW    = 18;
  localparam int unsigned IntegW   = 48;
  localparam int unsigned ClampW   = 47;
  localparam int unsigned SumW     = 49;
  localparam int unsigned DivW     = 34;
  localparam int unsigned DerivW   = 35;
  localparam int unsigned SplitW   = 24;
  localparam int unsigned MulAW    = 17;
  localparam int unsigned MulBW    = 25;
  localparam int unsigned ProdW    = 42;
  localparam int unsigned AccW     = 68;
  localparam int unsigned FracW    = 24;
  localparam int unsigned QW       = AccW - FracW;
  localparam int unsigned PcW      = 4;
  localparam int unsigned DivCntW  = 6;
  localparam int unsigned DivSteps = 34;
  localparam int unsigned CfgAddrW = 6;
  localparam int unsigned CfgOffW  = 3;
  localparam int unsigned CfgDataW = 64;

  typedef enum logic [2:0] {
    REG_GAIN_PROP     = 3'd0,
    REG_GAIN_INTEG    = 3'd1,
    REG_GAIN_DERIV    = 3'd2,
    REG_INTEG_CLAMP   = 3'd3,
    REG_DRIVE_FLOOR   = 3'd4,
    REG_DRIVE_CEILING = 3'd5,
    REG_STEP_LIMIT    = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [DataW-1:0] gain_prop;
    logic signed [DataW-1:0] gain_integ;
    logic signed [DataW-1:0] gain_deriv;
    logic [ClampW-1:0]       integ_clamp;
    logic signed [DataW-1:0] drive_floor;
    logic signed [DataW-1:0] drive_ceiling;
    logic [DataW-1:0]        step_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    ACT_NOP,
    ACT_LOAD,
    ACT_PREP,
    ACT_INT_SUM,
    ACT_INT_CLAMP,
    ACT_DIV_INIT,
    ACT_DIV_STEP,
    ACT_DIV_END,
    ACT_FINISH,
    ACT_BAD,
    ACT_EMIT
  } act_e;

  typedef enum logic [1:0] {A_ERR, A_GP, A_GD, A_GI} asel_e;

  typedef enum logic [2:0] {B_DT, B_ERR, B_DLO, B_DHI, B_ILO, B_IHI} bsel_e;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_LD16, ACC_ADD0, ACC_ADD16, ACC_ADD24, ACC_ADD40
  } accop_e;

  typedef enum logic [2:0] {
    JMP_NEXT, JMP_IN_WAIT, JMP_ZERO_DT, JMP_DIV_LOOP, JMP_ALWAYS, JMP_OUT_WAIT
  } jmp_e;

  typedef struct packed {
    act_e           act;
    asel_e          a_sel;
    bsel_e          b_sel;
    logic           mul_en;
    accop_e         acc_op;
    jmp_e           jmp;
    logic [PcW-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic dt_zero;
    logic div_last;
    logic out_busy;
  } status_t;

  localparam logic [PcW-1:0] STEP_LOAD     = 4'd0;
  localparam logic [PcW-1:0] STEP_PREP     = 4'd1;
  localparam logic [PcW-1:0] STEP_MUL_I    = 4'd2;
  localparam logic [PcW-1:0] STEP_INT_SUM  = 4'd3;
  localparam logic [PcW-1:0] STEP_INT_CLMP = 4'd4;
  localparam logic [PcW-1:0] STEP_DIV_INIT = 4'd5;
  localparam logic [PcW-1:0] STEP_DIV_STEP = 4'd6;
  localparam logic [PcW-1:0] STEP_DIV_END  = 4'd7;
  localparam logic [PcW-1:0] STEP_MAC_0    = 4'd8;
  localparam logic [PcW-1:0] STEP_MAC_1    = 4'd9;
  localparam logic [PcW-1:0] STEP_MAC_2    = 4'd10;
  localparam logic [PcW-1:0] STEP_MAC_3    = 4'd11;
  localparam logic [PcW-1:0] STEP_MAC_4    = 4'd12;
  localparam logic [PcW-1:0] STEP_FINISH   = 4'd13;
  localparam logic [PcW-1:0] STEP_BAD      = 4'd14;
  localparam logic [PcW-1:0] STEP_EMIT     = 4'd15;

  function automatic ctrl_t uword(input act_e act, input asel_e a, input bsel_e b,
                                  input logic mul, input accop_e acc, input jmp_e jmp,
                                  input logic [PcW-1:0] tgt);
    ctrl_t w;
    w.act    = act;
    w.a_sel  = a;
    w.b_sel  = b;
    w.mul_en = mul;
    w.acc_op = acc;
    w.jmp    = jmp;
    w.target = tgt;
    return w;
  endfunction

  function automatic ctrl_t ucode(input logic [PcW-1:0] addr);
    ctrl_t w;
    unique case (addr)
      STEP_LOAD:     w = uword(ACT_LOAD, A_ERR, B_DT, 1'b0, ACC_HOLD, JMP_IN_WAIT, STEP_LOAD);
      STEP_PREP:     w = uword(ACT_PREP, A_ERR, B_DT, 1'b0, ACC_HOLD, JMP_ZERO_DT, STEP_BAD);
      STEP_MUL_I:    w = uword(ACT_NOP, A_ERR, B_DT, 1'b1, ACC_HOLD, JMP_NEXT, STEP_LOAD);
      STEP_INT_SUM:  w = uword(ACT_INT_SUM, A_ERR, B_DT, 1'b0, ACC_HOLD, JMP_NEXT, STEP_LOAD);
      STEP_INT_CLMP: w = uword(ACT_INT_CLAMP, A_ERR, B_DT, 1'b0, ACC_HOLD, JMP_NEXT,
                               STEP_LOAD);
      STEP_DIV_INIT: w = uword(ACT_DIV_INIT, A_ERR, B_DT, 1'b0, ACC_HOLD, JMP_NEXT,
                               STEP_LOAD);
      STEP_DIV_STEP: w = uword(ACT_DIV_STEP, A_ERR, B_DT, 1'b0, ACC_HOLD, JMP_DIV_LOOP,
                               STEP_DIV_STEP);
      STEP_DIV_END:  w = uword(ACT_DIV_END, A_GP, B_ERR, 1'b1, ACC_HOLD, JMP_NEXT, STEP_LOAD);
      STEP_MAC_0:    w = uword(ACT_NOP, A_GD, B_DLO, 1'b1, ACC_LD16, JMP_NEXT, STEP_LOAD);
      STEP_MAC_1:    w = uword(ACT_NOP, A_GD, B_DHI, 1'b1, ACC_ADD16, JMP_NEXT, STEP_LOAD);
      STEP_MAC_2:    w = uword(ACT_NOP, A_GI, B_ILO, 1'b1, ACC_ADD40, JMP_NEXT, STEP_LOAD);
      STEP_MAC_3:    w = uword(ACT_NOP, A_GI, B_IHI, 1'b1, ACC_ADD0, JMP_NEXT, STEP_LOAD);
      STEP_MAC_4:    w = uword(ACT_NOP, A_ERR, B_DT, 1'b0, ACC_ADD24, JMP_NEXT, STEP_LOAD);
      STEP_FINISH:   w = uword(ACT_FINISH, A_ERR, B_DT, 1'b0, ACC_HOLD, JMP_ALWAYS,
                               STEP_EMIT);
      STEP_BAD:      w = uword(ACT_BAD, A_ERR, B_DT, 1'b0, ACC_HOLD, JMP_NEXT, STEP_LOAD);
      STEP_EMIT:     w = uword(ACT_EMIT, A_ERR, B_DT, 1'b0, ACC_HOLD, JMP_OUT_WAIT,
                               STEP_LOAD);
      default:       w = uword(ACT_NOP, A_ERR, B_DT, 1'b0, ACC_HOLD, JMP_ALWAYS, STEP_LOAD);
    endcase
    return w;
  endfunction

endpackage

FILE: design/pidaw_in_if.sv
// ----------------------------------------------------------------------------
// PID controller input channel
// Valid/ready channel carrying setpoint, measurement and time step.
// ----------------------------------------------------------------------------
interface pidaw_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pidaw_pkg::DataW-1:0]    target;
  logic signed [pidaw_pkg::DataW-1:0]    measured;
  logic [pidaw_pkg::DataW-1:0]           step_time;

  modport source (output valid, target, measured, step_time, input ready);
  modport sink   (input valid, target, measured, step_time, output ready);
endinterface

FILE: design/pidaw_out_if.sv
// ----------------------------------------------------------------------------
// PID controller output channel
// Valid/ready channel carrying the saturated drive and the bad step flag.
// ----------------------------------------------------------------------------
interface pidaw_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pidaw_pkg::DataW-1:0] drive;
  logic                               bad_step;

  modport source (output valid, drive, bad_step, input ready);
  modport sink   (input valid, drive, bad_step, output ready);
endinterface

FILE: design/pidaw_regs.sv
// ----------------------------------------------------------------------------
// PID controller configuration registers
// APB-style register file holding gains, limits and the step limit.
// ----------------------------------------------------------------------------
module pidaw_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [pidaw_pkg::CfgAddrW-1:0]     paddr,
  input  logic [pidaw_pkg::CfgDataW-1:0]     pwdata,
  output logic [pidaw_pkg::CfgDataW-1:0]     prdata,
  output logic                               pready,
  output pidaw_pkg::cfg_t                    cfg_o
);

  localparam int unsigned PadW = pidaw_pkg::CfgDataW - pidaw_pkg::DataW;
  localparam int unsigned PadC = pidaw_pkg::CfgDataW - pidaw_pkg::ClampW;

  pidaw_pkg::cfg_t     cfg_q;
  pidaw_pkg::reg_idx_e idx;

  assign idx    = pidaw_pkg::reg_idx_e'(paddr[pidaw_pkg::CfgAddrW-1:pidaw_pkg::CfgOffW]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_prop     <= 16'sd256;
      cfg_q.gain_integ    <= '0;
      cfg_q.gain_deriv    <= '0;
      cfg_q.integ_clamp   <= '1;
      cfg_q.drive_floor   <= 16'sh8000;
      cfg_q.drive_ceiling <= 16'sh7fff;
      cfg_q.step_limit    <= '1;
    end else if (psel && penable && pwrite) begin
      case (idx)
        pidaw_pkg::REG_GAIN_PROP:     cfg_q.gain_prop     <= pwdata[pidaw_pkg::DataW-1:0];
        pidaw_pkg::REG_GAIN_INTEG:    cfg_q.gain_integ    <= pwdata[pidaw_pkg::DataW-1:0];
        pidaw_pkg::REG_GAIN_DERIV:    cfg_q.gain_deriv    <= pwdata[pidaw_pkg::DataW-1:0];
        pidaw_pkg::REG_INTEG_CLAMP:   cfg_q.integ_clamp   <= pwdata[pidaw_pkg::ClampW-1:0];
        pidaw_pkg::REG_DRIVE_FLOOR:   cfg_q.drive_floor   <= pwdata[pidaw_pkg::DataW-1:0];
        pidaw_pkg::REG_DRIVE_CEILING: cfg_q.drive_ceiling <= pwdata[pidaw_pkg::DataW-1:0];
        pidaw_pkg::REG_STEP_LIMIT:    cfg_q.step_limit    <= pwdata[pidaw_pkg::DataW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      pidaw_pkg::REG_GAIN_PROP:     prdata = {{PadW{1'b0}}, cfg_q.gain_prop};
      pidaw_pkg::REG_GAIN_INTEG:    prdata = {{PadW{1'b0}}, cfg_q.gain_integ};
      pidaw_pkg::REG_GAIN_DERIV:    prdata = {{PadW{1'b0}}, cfg_q.gain_deriv};
      pidaw_pkg::REG_INTEG_CLAMP:   prdata = {{PadC{1'b0}}, cfg_q.integ_clamp};
      pidaw_pkg::REG_DRIVE_FLOOR:   prdata = {{PadW{1'b0}}, cfg_q.drive_floor};
      pidaw_pkg::REG_DRIVE_CEILING: prdata = {{PadW{1'b0}}, cfg_q.drive_ceiling};
      pidaw_pkg::REG_STEP_LIMIT:    prdata = {{PadW{1'b0}}, cfg_q.step_limit};
      default:                      prdata = '0;
    endcase
  end

endmodule

FILE: design/pidaw_seq.sv
// ----------------------------------------------------------------------------
// PID controller microcode sequencer
// Step counter over the control program with conditional jumps.
// ----------------------------------------------------------------------------
module pidaw_seq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pidaw_pkg::status_t status_i,
  output pidaw_pkg::ctrl_t   ctrl_o
);

  logic [pidaw_pkg::PcW-1:0] pc_q, pc_d, pc_inc;
  pidaw_pkg::ctrl_t          ctrl;

  assign ctrl   = pidaw_pkg::ucode(pc_q);
  assign ctrl_o = ctrl;
  assign pc_inc = pc_q + 1'b1;

  always_comb begin
    unique case (ctrl.jmp)
      pidaw_pkg::JMP_NEXT:     pc_d = pc_inc;
      pidaw_pkg::JMP_IN_WAIT:  pc_d = status_i.in_valid ? pc_inc : pc_q;
      pidaw_pkg::JMP_ZERO_DT:  pc_d = status_i.dt_zero ? ctrl.target : pc_inc;
      pidaw_pkg::JMP_DIV_LOOP: pc_d = status_i.div_last ? pc_inc : ctrl.target;
      pidaw_pkg::JMP_ALWAYS:   pc_d = ctrl.target;
      pidaw_pkg::JMP_OUT_WAIT: pc_d = status_i.out_busy ? pc_q : ctrl.target;
      default:                 pc_d = pidaw_pkg::STEP_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= pidaw_pkg::STEP_LOAD;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

FILE: design/pidaw_dp.sv
// ----------------------------------------------------------------------------
// PID controller datapath
// Shared multiplier, accumulator, radix-2 divider and the output register.
// ----------------------------------------------------------------------------
module pidaw_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pidaw_pkg::cfg_t    cfg_i,
  input  pidaw_pkg::ctrl_t   ctrl_i,
  output pidaw_pkg::status_t status_o,
  pidaw_in_if.sink           in_ch,
  pidaw_out_if.source        out_ch
);

  localparam int unsigned DataW  = pidaw_pkg::DataW;
  localparam int unsigned ErrW   = pidaw_pkg::ErrW;
  localparam int unsigned DiffW  = pidaw_pkg::DiffW;
  localparam int unsigned IntegW = pidaw_pkg::IntegW;
  localparam int unsigned SumW   = pidaw_pkg::SumW;
  localparam int unsigned DivW   = pidaw_pkg::DivW;
  localparam int unsigned DerivW = pidaw_pkg::DerivW;
  localparam int unsigned SplitW = pidaw_pkg::SplitW;
  localparam int unsigned MulAW  = pidaw_pkg::MulAW;
  localparam int unsigned MulBW  = pidaw_pkg::MulBW;
  localparam int unsigned ProdW  = pidaw_pkg::ProdW;
  localparam int unsigned AccW   = pidaw_pkg::AccW;
  localparam int unsigned FracW  = pidaw_pkg::FracW;
  localparam int unsigned QW     = pidaw_pkg::QW;
  localparam int unsigned CntW   = pidaw_pkg::DivCntW;

  logic signed [DataW-1:0]  tgt_q, meas_q;
  logic [DataW-1:0]         dt_raw_q, dt_q, dt_d, lim;
  logic signed [ErrW-1:0]   err_q, err_d, last_err_q;
  logic signed [IntegW-1:0] integ_q, integ_d;
  logic signed [SumW-1:0]   sum_q, sum_d, lim_pos, lim_neg, integ_ext;
  logic signed [DerivW-1:0] deriv_q, deriv_d;
  logic [DivW-1:0]          quot_q, quot_d;
  logic [DataW-1:0]         rem_q, rem_d;
  logic [DataW:0]           trial, trial_sub;
  logic [CntW-1:0]          cnt_q, cnt_d;
  logic                     neg_q, neg_d;
  logic signed [DiffW-1:0]  diff;
  logic [DiffW-1:0]         mag;
  logic signed [MulAW-1:0]  mul_a;
  logic signed [MulBW-1:0]  mul_b;
  logic signed [ProdW-1:0]  prod_q, prod_d;
  logic signed [AccW-1:0]   acc_q, acc_d, prod_ext;
  logic signed [QW-1:0]     q_val, ceil_ext, floor_ext;
  logic signed [DataW-1:0]  res_drive_q, res_drive_d, out_drive_q, out_drive_d;
  logic                     res_bad_q, res_bad_d, out_bad_q, out_bad_d;
  logic                     out_valid_q, out_valid_d, out_busy, load;

  assign load       = (ctrl_i.act == pidaw_pkg::ACT_LOAD) && in_ch.valid;
  assign in_ch.ready = (ctrl_i.act == pidaw_pkg::ACT_LOAD);
  assign out_busy   = out_valid_q && !out_ch.ready;

  assign status_o.in_valid = in_ch.valid;
  assign status_o.dt_zero  = (dt_raw_q == '0);
  assign status_o.div_last = (cnt_q == CntW'(1));
  assign status_o.out_busy = out_busy;

  assign out_ch.valid    = out_valid_q;
  assign out_ch.drive    = out_drive_q;
  assign out_ch.bad_step = out_bad_q;

  always_comb begin
    case (ctrl_i.a_sel)
      pidaw_pkg::A_ERR: mul_a = err_q;
      pidaw_pkg::A_GP:  mul_a = MulAW'(cfg_i.gain_prop);
      pidaw_pkg::A_GD:  mul_a = MulAW'(cfg_i.gain_deriv);
      pidaw_pkg::A_GI:  mul_a = MulAW'(cfg_i.gain_integ);
      default:          mul_a = '0;
    endcase
    case (ctrl_i.b_sel)
      pidaw_pkg::B_DT:  mul_b = {{(MulBW-DataW){1'b0}}, dt_q};
      pidaw_pkg::B_ERR: mul_b = MulBW'(err_q);
      pidaw_pkg::B_DLO: mul_b = {1'b0, deriv_q[SplitW-1:0]};
      pidaw_pkg::B_DHI: mul_b = {{(MulBW-DerivW+SplitW){deriv_q[DerivW-1]}},
                                 deriv_q[DerivW-1:SplitW]};
      pidaw_pkg::B_ILO: mul_b = {1'b0, integ_q[SplitW-1:0]};
      pidaw_pkg::B_IHI: mul_b = {integ_q[IntegW-1], integ_q[IntegW-1:SplitW]};
      default:          mul_b = '0;
    endcase
    prod_d = mul_a * mul_b;
  end

  always_comb begin
    prod_ext = AccW'(prod_q);
    case (ctrl_i.acc_op)
      pidaw_pkg::ACC_LD16:  acc_d = prod_ext <<< 16;
      pidaw_pkg::ACC_ADD0:  acc_d = acc_q + prod_ext;
      pidaw_pkg::ACC_ADD16: acc_d = acc_q + (prod_ext <<< 16);
      pidaw_pkg::ACC_ADD24: acc_d = acc_q + (prod_ext <<< 24);
      pidaw_pkg::ACC_ADD40: acc_d = acc_q + (prod_ext <<< 40);
      default:              acc_d = acc_q;
    endcase
  end

  always_comb begin
    lim       = (cfg_i.step_limit == '0) ? DataW'(1) : cfg_i.step_limit;
    dt_d      = (dt_raw_q > lim) ? lim : dt_raw_q;
    err_d     = ErrW'(tgt_q) - ErrW'(meas_q);
    sum_d     = SumW'(integ_q) + SumW'(prod_q);
    lim_pos   = {{(SumW-pidaw_pkg::ClampW){1'b0}}, cfg_i.integ_clamp};
    lim_neg   = -lim_pos;
    integ_ext = SumW'(integ_q);
    if (sum_q > lim_pos) begin
      integ_d = lim_pos[IntegW-1:0];
    end else if (sum_q < lim_neg) begin
      integ_d = lim_neg[IntegW-1:0];
    end else begin
      integ_d = sum_q[IntegW-1:0];
    end
  end

  always_comb begin
    diff      = DiffW'(err_q) - DiffW'(last_err_q);
    neg_d     = diff[DiffW-1];
    mag       = neg_d ? -diff : diff;
    trial     = {rem_q, quot_q[DivW-1]};
    trial_sub = trial - {1'b0, dt_q};
    rem_d     = rem_q;
    quot_d    = quot_q;
    cnt_d     = cnt_q;
    if (ctrl_i.act == pidaw_pkg::ACT_DIV_INIT) begin
      rem_d  = '0;
      quot_d = {mag[DivW-DataW-1:0], {DataW{1'b0}}};
      cnt_d  = CntW'(pidaw_pkg::DivSteps);
    end else if (ctrl_i.act == pidaw_pkg::ACT_DIV_STEP) begin
      if (trial >= {1'b0, dt_q}) begin
        rem_d  = trial_sub[DataW-1:0];
        quot_d = {quot_q[DivW-2:0], 1'b1};
      end else begin
        rem_d  = trial[DataW-1:0];
        quot_d = {quot_q[DivW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
    end
    deriv_d = neg_q ? -{1'b0, quot_q} : {1'b0, quot_q};
  end

  always_comb begin
    q_val     = $signed(acc_q[AccW-1:FracW]) +
                QW'(acc_q[AccW-1] && (acc_q[FracW-1:0] != '0));
    ceil_ext  = QW'(cfg_i.drive_ceiling);
    floor_ext = QW'(cfg_i.drive_floor);
    res_drive_d = res_drive_q;
    res_bad_d   = res_bad_q;
    if (ctrl_i.act == pidaw_pkg::ACT_FINISH) begin
      res_bad_d = 1'b0;
      if (q_val > ceil_ext) begin
        res_drive_d = cfg_i.drive_ceiling;
      end else if (q_val < floor_ext) begin
        res_drive_d = cfg_i.drive_floor;
      end else begin
        res_drive_d = q_val[DataW-1:0];
      end
    end else if (ctrl_i.act == pidaw_pkg::ACT_BAD) begin
      res_drive_d = '0;
      res_bad_d   = 1'b1;
    end
    out_valid_d = out_valid_q && !out_ch.ready;
    out_drive_d = out_drive_q;
    out_bad_d   = out_bad_q;
    if ((ctrl_i.act == pidaw_pkg::ACT_EMIT) && !out_busy) begin
      out_valid_d = 1'b1;
      out_drive_d = res_drive_q;
      out_bad_d   = res_bad_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      integ_q     <= '0;
      last_err_q  <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      if (ctrl_i.act == pidaw_pkg::ACT_INT_CLAMP) begin
        integ_q <= integ_d;
      end
      if (ctrl_i.act == pidaw_pkg::ACT_DIV_END) begin
        last_err_q <= err_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      tgt_q    <= in_ch.target;
      meas_q   <= in_ch.measured;
      dt_raw_q <= in_ch.step_time;
    end
    if (ctrl_i.act == pidaw_pkg::ACT_PREP) begin
      err_q <= err_d;
      dt_q  <= dt_d;
    end
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.act == pidaw_pkg::ACT_INT_SUM) begin
      sum_q <= sum_d;
    end
    if (ctrl_i.act == pidaw_pkg::ACT_DIV_INIT) begin
      neg_q <= neg_d;
    end
    if (ctrl_i.act == pidaw_pkg::ACT_DIV_END) begin
      deriv_q <= deriv_d;
    end
    rem_q       <= rem_d;
    quot_q      <= quot_d;
    cnt_q       <= cnt_d;
    acc_q       <= acc_d;
    res_drive_q <= res_drive_d;
    res_bad_q   <= res_bad_d;
    out_drive_q <= out_drive_d;
    out_bad_q   <= out_bad_d;
  end

  a_div_rem_below_dt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.act == pidaw_pkg::ACT_DIV_STEP) |-> (rem_q < dt_q))
    else $error("Divider remainder is not below the time step.");

  a_integ_in_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.act == pidaw_pkg::ACT_INT_CLAMP) |=>
      ((integ_ext <= lim_pos) && (integ_ext >= lim_neg)))
    else $error("Integral left the clamp range.");

  a_bad_step_zero_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_bad_q) |-> (out_drive_q == '0))
    else $error("A zero step result carries a nonzero drive.");

endmodule

FILE: design/pid_controller_antiwindup_unit.sv
// ----------------------------------------------------------------------------
// PID controller with integral clamp
// Fixed-point PID update driven by a microcoded sequencer.
// ----------------------------------------------------------------------------
// Each transfer on in_ch brings a setpoint, a measurement and a time step in
// Q0.16 seconds; each one yields exactly one transfer on out_ch with the
// saturated drive and a flag that is set when the time step was zero.
// Gains, the integral limit, the drive range and the step limit are to be
// written over the APB-style port while no update is in progress; the block
// does not enforce this. An update runs the integral steps, 34 iterations of
// the radix-2 divider that forms the derivative and six passes through the
// shared multiplier before its result is offered, and the next input is taken
// once that result enters the output register. A zero time step skips to a
// zero-drive result. The result sits in an output register; while the receiver
// stalls the next item is accepted and computed, and waits at its last step.
// Reset clears the integral and the previous error, loads the default
// registers and leaves the block ready for input with no result pending.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pidaw_pkg::CfgAddrW-1:0] paddr,
  input  logic [pidaw_pkg::CfgDataW-1:0] pwdata,
  output logic [pidaw_pkg::CfgDataW-1:0] prdata,
  output logic                           pready,
  pidaw_in_if.sink                       in_ch,
  pidaw_out_if.source                    out_ch
);

  pidaw_pkg::cfg_t    cfg;
  pidaw_pkg::ctrl_t   ctrl;
  pidaw_pkg::status_t status;

  pidaw_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pidaw_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  pidaw_dp u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .ctrl_i   (ctrl),
    .status_o (status),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

endmodule

FILE: test/pid_controller_antiwindup_unit_test.sv
// ----------------------------------------------------------------------------
// PID controller with integral clamp: block-level test
// Drives setpoint, measurement and time step transfers into the controller,
// computes each expected drive with a fixed-point model of the update, and
// checks every output transfer in order. Gains, limits and the step limit are
// reprogrammed over the APB port between phases, both channels idle at
// random, and the receiver holds off for a long stretch once.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module pid_controller_antiwindup_unit_test;

  localparam int unsigned SettleCycles = 60;
  localparam int unsigned QuietLimit   = 2000;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned PhaseItems   = 150;
  localparam int unsigned RandPhases   = 9;
  localparam int unsigned IdlePct      = 37;

  typedef struct packed {
    logic signed [pidaw_pkg::DataW-1:0] target;
    logic signed [pidaw_pkg::DataW-1:0] measured;
    logic [pidaw_pkg::DataW-1:0]        step_time;
  } pid_sample_t;

  typedef struct packed {
    logic signed [pidaw_pkg::DataW-1:0] drive;
    logic                               bad_step;
  } drive_result_t;

  logic                           clk;
  logic                           rst_n;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [pidaw_pkg::CfgAddrW-1:0] paddr;
  logic [pidaw_pkg::CfgDataW-1:0] pwdata;
  logic [pidaw_pkg::CfgDataW-1:0] prdata;
  logic                           pready;

  pidaw_in_if  in_ch ();
  pidaw_out_if out_ch ();

  pid_controller_antiwindup_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  pidaw_pkg::cfg_t active_cfg;
  longint          integral_q16;
  longint          last_err_model;
  pid_sample_t     pending_samples[$];
  pid_sample_t     offered;
  drive_result_t   expected_drives[$];
  int unsigned     in_transfers;
  int unsigned     mismatch_count;
  int unsigned     quiet_cycles;
  int unsigned     tx_idle_pct;
  int unsigned     rx_idle_pct;
  logic            rx_hold;

  initial begin
    clk = 1'b0;
  end

  always #2 clk = ~clk;

  function automatic drive_result_t pid_update(input pid_sample_t s);
    drive_result_t r;
    longint        err;
    longint        dt;
    longint        lim;
    longint        clamp;
    longint        deriv;
    longint        pd;
    longint        iterm;
    longint        ihi;
    longint        ilo;
    longint        sum;
    longint        q;
    r.drive    = '0;
    r.bad_step = 1'b1;
    if (s.step_time == '0) begin
      return r;
    end
    r.bad_step = 1'b0;
    lim = (active_cfg.step_limit == '0) ? 64'sd1 : longint'(active_cfg.step_limit);
    dt  = longint'(s.step_time);
    if (dt > lim) begin
      dt = lim;
    end
    err   = longint'($signed(s.target)) - longint'($signed(s.measured));
    clamp = longint'(active_cfg.integ_clamp);
    integral_q16 = integral_q16 + err * dt;
    if (integral_q16 > clamp) begin
      integral_q16 = clamp;
    end else if (integral_q16 < -clamp) begin
      integral_q16 = -clamp;
    end
    deriv          = ((err - last_err_model) * 64'sd65536) / dt;
    last_err_model = err;
    pd    = longint'($signed(active_cfg.gain_prop)) * err
          + longint'($signed(active_cfg.gain_deriv)) * deriv;
    iterm = longint'($signed(active_cfg.gain_integ)) * integral_q16;
    ihi   = iterm >>> 16;
    ilo   = longint'(iterm[15:0]);
    sum   = pd + ihi;
    q     = sum >>> 8;
    if (sum < 0 && !(sum[7:0] == 8'd0 && ilo == 0)) begin
      q = q + 1;
    end
    if (q > longint'($signed(active_cfg.drive_ceiling))) begin
      q = longint'($signed(active_cfg.drive_ceiling));
    end else if (q < longint'($signed(active_cfg.drive_floor))) begin
      q = longint'($signed(active_cfg.drive_floor));
    end
    r.drive = q[pidaw_pkg::DataW-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 100) begin
      $display("%0t mismatch: %s", $time, what);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_drives.push_back(pid_update(offered));
        in_transfers++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_samples.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
          offered = pending_samples.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.target    <= offered.target;
          in_ch.measured  <= offered.measured;
          in_ch.step_time <= offered.step_time;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    drive_result_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_drives.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: drive %0d bad_step %0b",
                                    out_ch.drive, out_ch.bad_step));
        end else begin
          want = expected_drives.pop_front();
          if (out_ch.drive !== want.drive) begin
            report_mismatch($sformatf("drive %0d, wanted %0d", out_ch.drive, want.drive));
          end
          if (out_ch.bad_step !== want.bad_step) begin
            report_mismatch($sformatf("bad_step %0b, wanted %0b", out_ch.bad_step,
                                      want.bad_step));
          end
        end
      end
      out_ch.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("pid_controller_antiwindup_unit_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rx_hold = 1'b0;
    do @(negedge clk); while (in_transfers < 600 || pending_samples.size() < 40);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic write_register(input pidaw_pkg::reg_idx_e idx,
                                input logic [pidaw_pkg::CfgDataW-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, {pidaw_pkg::CfgOffW{1'b0}}};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      pidaw_pkg::REG_GAIN_PROP:     active_cfg.gain_prop     = value[pidaw_pkg::DataW-1:0];
      pidaw_pkg::REG_GAIN_INTEG:    active_cfg.gain_integ    = value[pidaw_pkg::DataW-1:0];
      pidaw_pkg::REG_GAIN_DERIV:    active_cfg.gain_deriv    = value[pidaw_pkg::DataW-1:0];
      pidaw_pkg::REG_INTEG_CLAMP:   active_cfg.integ_clamp   = value[pidaw_pkg::ClampW-1:0];
      pidaw_pkg::REG_DRIVE_FLOOR:   active_cfg.drive_floor   = value[pidaw_pkg::DataW-1:0];
      pidaw_pkg::REG_DRIVE_CEILING: active_cfg.drive_ceiling = value[pidaw_pkg::DataW-1:0];
      pidaw_pkg::REG_STEP_LIMIT:    active_cfg.step_limit    = value[pidaw_pkg::DataW-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apply_settings(input pidaw_pkg::cfg_t c);
    write_register(pidaw_pkg::REG_GAIN_PROP, pidaw_pkg::CfgDataW'(c.gain_prop));
    write_register(pidaw_pkg::REG_GAIN_INTEG, pidaw_pkg::CfgDataW'(c.gain_integ));
    write_register(pidaw_pkg::REG_GAIN_DERIV, pidaw_pkg::CfgDataW'(c.gain_deriv));
    write_register(pidaw_pkg::REG_INTEG_CLAMP, pidaw_pkg::CfgDataW'(c.integ_clamp));
    write_register(pidaw_pkg::REG_DRIVE_FLOOR, pidaw_pkg::CfgDataW'(c.drive_floor));
    write_register(pidaw_pkg::REG_DRIVE_CEILING, pidaw_pkg::CfgDataW'(c.drive_ceiling));
    write_register(pidaw_pkg::REG_STEP_LIMIT, pidaw_pkg::CfgDataW'(c.step_limit));
  endtask

  task automatic queue_sample(input logic [pidaw_pkg::DataW-1:0] t,
                              input logic [pidaw_pkg::DataW-1:0] m,
                              input logic [pidaw_pkg::DataW-1:0] dt);
    pid_sample_t s;
    s.target    = t;
    s.measured  = m;
    s.step_time = dt;
    pending_samples.push_back(s);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_ch.valid || expected_drives.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic [pidaw_pkg::DataW-1:0] random_gain();
    case ($urandom_range(0, 3))
      0:       return ($urandom_range(0, 1) != 0) ? 16'h8000 : 16'h7FFF;
      1:       return pidaw_pkg::DataW'($urandom_range(0, 1023)) - 16'd512;
      default: return pidaw_pkg::DataW'($urandom);
    endcase
  endfunction

  function automatic pid_sample_t random_sample();
    pid_sample_t s;
    int unsigned roll;
    s.target = pidaw_pkg::DataW'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      s.measured = s.target - pidaw_pkg::DataW'($urandom_range(0, 64)) + 16'd32;
    end else begin
      s.measured = pidaw_pkg::DataW'($urandom);
    end
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      s.step_time = '0;
    end else if (roll < 12) begin
      s.step_time = 16'hFFFF;
    end else if (roll < 45) begin
      s.step_time = pidaw_pkg::DataW'($urandom_range(1, 255));
    end else begin
      s.step_time = pidaw_pkg::DataW'($urandom_range(1, 65535));
    end
    return s;
  endfunction

  function automatic pidaw_pkg::cfg_t random_settings();
    pidaw_pkg::cfg_t c;
    c.gain_prop  = random_gain();
    c.gain_integ = random_gain();
    c.gain_deriv = random_gain();
    case ($urandom_range(0, 3))
      0:       c.integ_clamp = '0;
      1:       c.integ_clamp = '1;
      2:       c.integ_clamp = pidaw_pkg::ClampW'($urandom_range(0, 1 << 24));
      default: c.integ_clamp = pidaw_pkg::ClampW'({$urandom, $urandom});
    endcase
    if ($urandom_range(0, 4) == 0) begin
      c.drive_floor   = pidaw_pkg::DataW'($urandom);
      c.drive_ceiling = pidaw_pkg::DataW'($urandom);
    end else begin
      c.drive_floor   = -pidaw_pkg::DataW'($urandom_range(0, 32768));
      c.drive_ceiling = pidaw_pkg::DataW'($urandom_range(0, 32767));
    end
    case ($urandom_range(0, 4))
      0:       c.step_limit = '0;
      1:       c.step_limit = 16'd1;
      2:       c.step_limit = 16'hFFFF;
      default: c.step_limit = pidaw_pkg::DataW'($urandom);
    endcase
    return c;
  endfunction

  initial begin
    pidaw_pkg::cfg_t settings;
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_ch.valid     = 1'b0;
    in_ch.target    = '0;
    in_ch.measured  = '0;
    in_ch.step_time = '0;
    out_ch.ready    = 1'b0;
    tx_idle_pct     = IdlePct;
    rx_idle_pct     = IdlePct;
    in_transfers    = 0;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    integral_q16    = 0;
    last_err_model  = 0;
    active_cfg.gain_prop     = 16'sd256;
    active_cfg.gain_integ    = '0;
    active_cfg.gain_deriv    = '0;
    active_cfg.integ_clamp   = '1;
    active_cfg.drive_floor   = 16'h8000;
    active_cfg.drive_ceiling = 16'h7FFF;
    active_cfg.step_limit    = 16'hFFFF;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    @(negedge clk);
    queue_sample(16'd0, 16'd0, 16'd1);
    queue_sample(16'h7FFF, 16'h8000, 16'hFFFF);
    queue_sample(16'h8000, 16'h7FFF, 16'hFFFF);
    queue_sample(16'd100, 16'd40, 16'd0);
    queue_sample(-16'd5, 16'd3, 16'd1);
    wait_drained();

    settings.gain_prop     = 16'h0180;
    settings.gain_integ    = 16'h0100;
    settings.gain_deriv    = 16'h0008;
    settings.integ_clamp   = pidaw_pkg::ClampW'(48'h0010_0000);
    settings.drive_floor   = -16'd2000;
    settings.drive_ceiling = 16'd2000;
    settings.step_limit    = 16'h1000;
    apply_settings(settings);
    @(negedge clk);
    queue_sample(16'd10, 16'd0, 16'h8000);
    queue_sample(-16'd10, 16'd0, 16'h1000);
    queue_sample(16'd0, 16'd0, 16'd0);
    queue_sample(-16'd3, 16'd0, 16'hFFFF);
    queue_sample(16'h7FFF, 16'h8000, 16'd1);
    queue_sample(16'h8000, 16'h7FFF, 16'd1);
    queue_sample(16'd1, 16'd0, 16'd1);
    queue_sample(16'd0, 16'd1, 16'd3);
    wait_drained();

    // Floor above ceiling, zero step limit and gain extremes.
    settings.gain_prop     = 16'h8000;
    settings.gain_integ    = 16'h7FFF;
    settings.gain_deriv    = 16'hFFFF;
    settings.integ_clamp   = '0;
    settings.drive_floor   = 16'd100;
    settings.drive_ceiling = -16'd100;
    settings.step_limit    = '0;
    apply_settings(settings);
    @(negedge clk);
    queue_sample(16'd5, 16'd0, 16'd7);
    queue_sample(-16'd5, 16'd0, 16'd7);
    queue_sample(16'd0, 16'd0, 16'd0);
    queue_sample(16'd0, 16'd0, 16'd2);
    queue_sample(16'h7FFF, 16'h8000, 16'hFFFF);
    wait_drained();

    for (int phase = 0; phase < RandPhases; phase++) begin
      apply_settings(random_settings());
      @(posedge clk);
      tx_idle_pct <= (phase == 2) ? 0 : IdlePct;
      rx_idle_pct <= (phase == 2) ? 0 : IdlePct;
      @(negedge clk);
      repeat (PhaseItems) pending_samples.push_back(random_sample());
      wait_drained();
    end

    if (expected_drives.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_drives.size()));
    end
    if (mismatch_count == 0) begin
      $display("pid_controller_antiwindup_unit_test: clean");
    end else begin
      $display("pid_controller_antiwindup_unit_test: errors");
    end
    $finish;
  end

endmodule
